>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> src/rotb_pkg.sv
// ----------------------------------------------------------------------------
// rotb_pkg
// Shared constants and types of the bilinear image rotation core.
// ----------------------------------------------------------------------------
`default_nettype none

package rotb_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int WEIGHT_BITS = 8;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = X_W + Y_W;
  localparam int DIM_W  = 9;
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;

  // Source coordinates carry 15 fraction bits (half-pixel centre offset is exact).
  localparam int Q_BITS = 15;
  localparam int FX_LO  = Q_BITS - WEIGHT_BITS;

  // Shared multiply-accumulate unit.
  localparam int OPW   = 18;
  localparam int ACC_W = 30;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam int CFG_AW = 4;
  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 4'd0;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 4'd1;
  localparam logic [CFG_AW-1:0] CFG_COS    = 4'd2;
  localparam logic [CFG_AW-1:0] CFG_SIN    = 4'd3;

  typedef struct packed {
    logic                  en;
    logic                  load;
    logic signed [OPW-1:0] a;
    logic signed [OPW-1:0] b;
  } mac_op_t;

endpackage

`default_nettype wire

>>> src/rotb_frame_mem.sv
// ----------------------------------------------------------------------------
// rotb_frame_mem
// Single-port RGB frame store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rotb_frame_mem (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [rotb_pkg::ADDR_W-1:0]   addr,
  input  wire logic [rotb_pkg::PIX_W-1:0]    wdata,
  output logic      [rotb_pkg::PIX_W-1:0]    rdata
);

  logic [rotb_pkg::PIX_W-1:0] mem [(1 << rotb_pkg::ADDR_W)];
  logic [rotb_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/rotb_mac.sv
// ----------------------------------------------------------------------------
// rotb_mac
// Shared signed multiply-accumulate unit used for mapping and blending.
// ----------------------------------------------------------------------------
`default_nettype none

module rotb_mac (
  input  wire logic                              clk,
  input  wire rotb_pkg::mac_op_t                 op,
  output logic signed [rotb_pkg::ACC_W-1:0]      acc
);

  logic signed [2*rotb_pkg::OPW-1:0] prod_full;
  logic signed [rotb_pkg::ACC_W-1:0] prod;
  logic signed [rotb_pkg::ACC_W-1:0] acc_r;

  assign prod_full = op.a * op.b;
  assign prod      = prod_full[rotb_pkg::ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= op.load ? prod : acc_r + prod;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

>>> src/image_rotate_bilinear_core.sv
// ----------------------------------------------------------------------------
// image_rotate_bilinear_core
// RGB image rotation about the centre by inverse mapping, bilinear blend.
// ----------------------------------------------------------------------------
// A write beat (start with in_req_type low) stores one pixel when its position
// lies inside the configured size; busy stays low. A read beat computes the
// source coordinate on the shared multiply-accumulate unit, reads the four
// neighbors over the single frame-memory port, then runs three channels of
// two-step interpolation on the same multiply-accumulate unit. busy is high
// over these steps; the result strobe out_valid follows for one cycle, in which
// a new beat may already start. Results cannot be held off: sample them while
// out_valid is high. Configuration writes are always taken.
`default_nettype none
`include "assert_macros.svh"

module image_rotate_bilinear_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_req_type,
  input  wire logic [7:0]                     in_pos_x,
  input  wire logic [7:0]                     in_pos_y,
  input  wire logic [7:0]                     in_red_in,
  input  wire logic [7:0]                     in_green_in,
  input  wire logic [7:0]                     in_blue_in,
  output logic                                out_valid,
  output logic [7:0]                          out_red_out,
  output logic [7:0]                          out_green_out,
  output logic [7:0]                          out_blue_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rotb_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [15:0]                    cfg_data
);

  localparam int DX_W = 11;
  localparam int IX_W = rotb_pkg::ACC_W - rotb_pkg::Q_BITS + 1;
  localparam int WB   = rotb_pkg::WEIGHT_BITS;
  localparam int CW   = rotb_pkg::CH_W;

  localparam logic [2:0] COORD_SX   = 3'd3;
  localparam logic [2:0] COORD_LAST = 3'd6;
  localparam logic [2:0] FETCH_LAST = 3'd4;
  localparam logic [2:0] BLEND_T0   = 3'd2;
  localparam logic [2:0] BLEND_T1   = 3'd4;
  localparam logic [2:0] BLEND_LAST = 3'd6;
  localparam logic [1:0] CH_RED     = 2'd0;
  localparam logic [1:0] CH_GREEN   = 2'd1;
  localparam logic [1:0] CH_BLUE    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COORD = 4'b0010,
    S_FETCH = 4'b0100,
    S_BLEND = 4'b1000
  } state_t;

  function automatic logic [CW-1:0] chan_of(logic [rotb_pkg::PIX_W-1:0] p, logic [1:0] c);
    logic [CW-1:0] v;
    case (c)
      CH_RED:   v = p[23:16];
      CH_GREEN: v = p[15:8];
      default:  v = p[7:0];
    endcase
    return v;
  endfunction

  // Configuration
  logic [rotb_pkg::DIM_W-1:0] width_r, height_r;
  logic signed [15:0]         cos_r, sin_r;
  logic [rotb_pkg::DIM_W-1:0] w_eff, h_eff;

  // Sequencer and datapath registers
  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] chan_r, chan_nxt;
  logic signed [DX_W-1:0] dx2_r, dx2_nxt, dy2_r, dy2_nxt, neg_dx2;
  logic signed [rotb_pkg::ACC_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic inb_r, inb_nxt;
  logic [3:0][rotb_pkg::PIX_W-1:0] pix_r, pix_nxt;
  logic [15:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CW-1:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  // Fetch and blend helpers
  logic signed [IX_W-1:0] nx, ny;
  logic fetch_inb;
  logic [rotb_pkg::ADDR_W-1:0] fetch_addr, wr_addr, mem_addr;
  logic wr_inb, mem_we;
  logic [rotb_pkg::PIX_W-1:0] mem_rdata;
  logic [1:0] pix_idx;
  logic [WB-1:0] fx, fy;
  logic [WB:0] inv_fx, inv_fy;
  logic signed [rotb_pkg::ACC_W-1:0] acc;
  rotb_pkg::mac_op_t mac_op;
  logic [CW-1:0] ch_res;
  logic rd_take, blue_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rotb_pkg::DIM_W'(256);
      height_r <= rotb_pkg::DIM_W'(256);
      cos_r    <= 16'sd16384;
      sin_r    <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        rotb_pkg::CFG_WIDTH:  width_r  <= cfg_data[rotb_pkg::DIM_W-1:0];
        rotb_pkg::CFG_HEIGHT: height_r <= cfg_data[rotb_pkg::DIM_W-1:0];
        rotb_pkg::CFG_COS:    cos_r    <= cfg_data;
        rotb_pkg::CFG_SIN:    sin_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..MAX
  always_comb begin
    if (width_r == '0) begin
      w_eff = rotb_pkg::DIM_W'(1);
    end else if (width_r > rotb_pkg::DIM_W'(rotb_pkg::MAX_WIDTH)) begin
      w_eff = rotb_pkg::DIM_W'(rotb_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = rotb_pkg::DIM_W'(1);
    end else if (height_r > rotb_pkg::DIM_W'(rotb_pkg::MAX_HEIGHT)) begin
      h_eff = rotb_pkg::DIM_W'(rotb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Neighbor address: step bit 0 steps right, bit 1 steps down
  always_comb begin
    nx = IX_W'($signed(sx_r[rotb_pkg::ACC_W-1:rotb_pkg::Q_BITS]))
         + $signed({{(IX_W-1){1'b0}}, step_r[0]});
    ny = IX_W'($signed(sy_r[rotb_pkg::ACC_W-1:rotb_pkg::Q_BITS]))
         + $signed({{(IX_W-1){1'b0}}, step_r[1]});
    fetch_inb = !nx[IX_W-1] && (nx < $signed(IX_W'(w_eff)))
             && !ny[IX_W-1] && (ny < $signed(IX_W'(h_eff)));
    fetch_addr = {ny[rotb_pkg::Y_W-1:0], nx[rotb_pkg::X_W-1:0]};
  end

  assign wr_addr  = {in_pos_y, in_pos_x};
  assign wr_inb   = ({1'b0, in_pos_x} < w_eff) && ({1'b0, in_pos_y} < h_eff);
  assign mem_we   = (state_r == S_IDLE) && start && (in_req_type == rotb_pkg::REQ_WRITE)
                    && wr_inb;
  assign mem_addr = (state_r == S_FETCH) ? fetch_addr : wr_addr;

  rotb_frame_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .rdata (mem_rdata)
  );

  assign fx      = sx_r[rotb_pkg::Q_BITS-1:rotb_pkg::FX_LO];
  assign fy      = sy_r[rotb_pkg::Q_BITS-1:rotb_pkg::FX_LO];
  assign inv_fx  = (WB+1)'(1 << WB) - {1'b0, fx};
  assign inv_fy  = (WB+1)'(1 << WB) - {1'b0, fy};
  assign neg_dx2 = -dx2_r;
  assign pix_idx = 2'(step_r - 3'd1);
  assign ch_res  = acc[2*WB+CW-1:2*WB];

  // Operand selection for the shared unit
  always_comb begin
    mac_op = '0;
    unique case (state_r)
      S_COORD: begin
        mac_op.en   = (step_r < COORD_LAST);
        mac_op.load = (step_r == 3'd0) || (step_r == COORD_SX);
        case (step_r)
          3'd0: begin
            mac_op.a = rotb_pkg::OPW'(cos_r);
            mac_op.b = rotb_pkg::OPW'(dx2_r);
          end
          3'd1: begin
            mac_op.a = rotb_pkg::OPW'(sin_r);
            mac_op.b = rotb_pkg::OPW'(dy2_r);
          end
          3'd2: begin
            mac_op.a = $signed(rotb_pkg::OPW'(w_eff));
            mac_op.b = rotb_pkg::OPW'(16384);
          end
          3'd3: begin
            mac_op.a = rotb_pkg::OPW'(cos_r);
            mac_op.b = rotb_pkg::OPW'(dy2_r);
          end
          3'd4: begin
            mac_op.a = rotb_pkg::OPW'(sin_r);
            mac_op.b = rotb_pkg::OPW'(neg_dx2);
          end
          default: begin
            mac_op.a = $signed(rotb_pkg::OPW'(h_eff));
            mac_op.b = rotb_pkg::OPW'(16384);
          end
        endcase
      end
      S_BLEND: begin
        mac_op.en   = (step_r < BLEND_LAST);
        mac_op.load = (step_r == 3'd0) || (step_r == BLEND_T0) || (step_r == BLEND_T1);
        case (step_r)
          3'd0: begin
            mac_op.a = $signed(rotb_pkg::OPW'(chan_of(pix_r[0], chan_r)));
            mac_op.b = $signed(rotb_pkg::OPW'(inv_fx));
          end
          3'd1: begin
            mac_op.a = $signed(rotb_pkg::OPW'(chan_of(pix_r[1], chan_r)));
            mac_op.b = $signed(rotb_pkg::OPW'(fx));
          end
          3'd2: begin
            mac_op.a = $signed(rotb_pkg::OPW'(chan_of(pix_r[2], chan_r)));
            mac_op.b = $signed(rotb_pkg::OPW'(inv_fx));
          end
          3'd3: begin
            mac_op.a = $signed(rotb_pkg::OPW'(chan_of(pix_r[3], chan_r)));
            mac_op.b = $signed(rotb_pkg::OPW'(fx));
          end
          3'd4: begin
            mac_op.a = $signed(rotb_pkg::OPW'(t0_r));
            mac_op.b = $signed(rotb_pkg::OPW'(inv_fy));
          end
          default: begin
            mac_op.a = $signed(rotb_pkg::OPW'(t1_r));
            mac_op.b = $signed(rotb_pkg::OPW'(fy));
          end
        endcase
      end
      default: ;
    endcase
  end

  rotb_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    chan_nxt      = chan_r;
    dx2_nxt       = dx2_r;
    dy2_nxt       = dy2_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    inb_nxt       = inb_r;
    pix_nxt       = pix_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start && (in_req_type == rotb_pkg::REQ_READ)) begin
          state_nxt = S_COORD;
          step_nxt  = 3'd0;
          dx2_nxt   = $signed(DX_W'({in_pos_x, 1'b0})) - $signed(DX_W'(w_eff));
          dy2_nxt   = $signed(DX_W'({in_pos_y, 1'b0})) - $signed(DX_W'(h_eff));
        end
      end
      S_COORD: begin
        step_nxt = step_r + 3'd1;
        if (step_r == COORD_SX) begin
          sx_nxt = acc;
        end
        if (step_r == COORD_LAST) begin
          sy_nxt    = acc;
          state_nxt = S_FETCH;
          step_nxt  = 3'd0;
        end
      end
      S_FETCH: begin
        step_nxt = step_r + 3'd1;
        inb_nxt  = fetch_inb;
        // read data arrives in the cycle after its address is applied
        if (step_r != 3'd0) begin
          pix_nxt[pix_idx] = inb_r ? mem_rdata : '0;
        end
        if (step_r == FETCH_LAST) begin
          state_nxt = S_BLEND;
          step_nxt  = 3'd0;
          chan_nxt  = CH_RED;
        end
      end
      S_BLEND: begin
        step_nxt = step_r + 3'd1;
        if (step_r == BLEND_T0) begin
          t0_nxt = acc[15:0];
        end
        if (step_r == BLEND_T1) begin
          t1_nxt = acc[15:0];
        end
        if (step_r == BLEND_LAST) begin
          step_nxt = 3'd0;
          case (chan_r)
            CH_RED:   red_nxt   = ch_res;
            CH_GREEN: green_nxt = ch_res;
            default:  blue_nxt  = ch_res;
          endcase
          if (chan_r == CH_BLUE) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            chan_nxt = chan_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 3'd0;
      chan_r      <= CH_RED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx2_r   <= dx2_nxt;
    dy2_r   <= dy2_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    inb_r   <= inb_nxt;
    pix_r   <= pix_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

  assign rd_take   = start && !busy && (in_req_type == rotb_pkg::REQ_READ);
  assign blue_done = (state_r == S_BLEND) && (step_r == BLEND_LAST) && (chan_r == CH_BLUE);

  `ASSERT_NEXT(a_read_goes_busy, rd_take, busy, "read beat did not start the sequencer")
  `ASSERT_NEXT(a_result_after_blue, blue_done, out_valid && !busy, "missing result strobe")
  `ASSERT_CLK(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `ASSERT_CLK(a_mem_write_idle, mem_we |-> (state_r == S_IDLE), "frame write outside idle")

endmodule

`default_nettype wire
